FILE: rtl/dqe_pkg.sv
// ----------------------------------------------------------------------------
// DNS query encoder package
// Sizes, codes, microcode table and byte tables of the query encoder.
// ----------------------------------------------------------------------------
package dqe_pkg;

  // Name limits
  localparam int MAX_LABEL_BYTES = 63;
  localparam int MESSAGE_BYTES   = 512;
  localparam int QNAME_BUDGET    = MESSAGE_BYTES - 16;

  // Widths that follow from the limits
  localparam int LL_W   = $clog2(MAX_LABEL_BYTES + 1);
  localparam int ADDR_W = (MAX_LABEL_BYTES > 1) ? $clog2(MAX_LABEL_BYTES) : 1;
  localparam int IDX_W  = (ADDR_W > 4) ? ADDR_W : 4;
  localparam int NAME_W = $clog2(MESSAGE_BYTES);
  localparam int SUM_W  = NAME_W + 2;
  localparam int REM_W  = $clog2(MAX_LABEL_BYTES + 8);

  // Stream word widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Fixed parts of the message
  localparam int HDR_BYTES  = 12;
  localparam int TAIL_BYTES = 5;

  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_CHAR  = 2'd1,
    OP_END   = 2'd2
  } opcode_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_LONG  = 3'd2,
    ST_NAME  = 3'd3,
    ST_NOQ   = 3'd4
  } status_t;

  // Query phase
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_OPEN = 4'b0010,
    PH_HELD = 4'b0100,
    PH_FAIL = 4'b1000
  } phase_t;

  // Program being run
  typedef enum logic [1:0] {
    MODE_HDR = 2'd0,
    MODE_DOT = 2'd1,
    MODE_END = 2'd2
  } mode_t;

  // Byte source of a step
  typedef enum logic [2:0] {
    SRC_NONE = 3'd0,
    SRC_HDR  = 3'd1,
    SRC_LEN  = 3'd2,
    SRC_LBL  = 3'd3,
    SRC_TAIL = 3'd4,
    SRC_STAT = 3'd5
  } src_t;

  // Jump condition of a step
  typedef enum logic [1:0] {
    COND_NEVER = 2'd0,
    COND_EMPTY = 2'd1,
    COND_DOT   = 2'd2
  } cond_t;

  typedef logic [2:0] pc_t;

  // Program entry points
  localparam pc_t PC_HDR    = 3'd0;
  localparam pc_t PC_NAME   = 3'd1;
  localparam pc_t PC_TAIL   = 3'd4;
  localparam pc_t PC_DOTFIN = 3'd5;
  localparam pc_t PC_STAT   = 3'd6;

  // One control word
  typedef struct packed {
    src_t  src;
    logic  loop;
    cond_t cond;
    pc_t   target;
    logic  fin;
  } ctrl_t;

  // Microcode table
  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t c;
    c = '{src: SRC_NONE, loop: 1'b0, cond: COND_NEVER, target: PC_HDR, fin: 1'b1};
    unique case (pc)
      3'd0: c = '{src: SRC_HDR,  loop: 1'b1, cond: COND_NEVER, target: PC_HDR,    fin: 1'b1};
      3'd1: c = '{src: SRC_NONE, loop: 1'b0, cond: COND_EMPTY, target: PC_TAIL,   fin: 1'b0};
      3'd2: c = '{src: SRC_LEN,  loop: 1'b0, cond: COND_NEVER, target: PC_HDR,    fin: 1'b0};
      3'd3: c = '{src: SRC_LBL,  loop: 1'b1, cond: COND_DOT,   target: PC_DOTFIN, fin: 1'b0};
      3'd4: c = '{src: SRC_TAIL, loop: 1'b1, cond: COND_NEVER, target: PC_HDR,    fin: 1'b1};
      3'd5: c = '{src: SRC_NONE, loop: 1'b0, cond: COND_NEVER, target: PC_HDR,    fin: 1'b1};
      3'd6: c = '{src: SRC_STAT, loop: 1'b0, cond: COND_NEVER, target: PC_HDR,    fin: 1'b1};
      default: c = '{src: SRC_NONE, loop: 1'b0, cond: COND_NEVER, target: PC_HDR, fin: 1'b1};
    endcase
    return c;
  endfunction

  // Header: id, RD flag, one question, all counts else zero
  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] qid);
    logic [7:0] b;
    b = BYTE_ZERO;
    case (idx)
      4'd0: b = qid[15:8];
      4'd1: b = qid[7:0];
      4'd2: b = BYTE_ONE;
      4'd5: b = BYTE_ONE;
      default: b = BYTE_ZERO;
    endcase
    return b;
  endfunction

  // Root byte, QTYPE A, QCLASS IN
  function automatic logic [7:0] tail_byte(input logic [3:0] idx);
    logic [7:0] b;
    b = BYTE_ZERO;
    case (idx)
      4'd2: b = BYTE_ONE;
      4'd4: b = BYTE_ONE;
      default: b = BYTE_ZERO;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/dqe_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/dns_query_encoder_unit.sv
// ----------------------------------------------------------------------------
// DNS query encoder
// Builds a DNS query message (RD set, one question, type A, class IN) from a
// stream of start, character and end words, up to two message bytes per word out.
//
//   channel | dir | tdata (low bit first)                      | tuser / tlast
//   s_      | in  | query_id[15:0], char_code[23:16]           | tuser: opcode
//   m_      | out | byte_first, byte_second, byte_count,       | tlast:
//           |     | item_done, status, zero pad                | message_end
//
// A start word, a dot that closes a label and an end word each start a
// microcode program, and s_ waits while it runs; other character words run
// no program. The microcode sequencer emits at most one message byte per
// step. Back-pressure on m_ holds the step that emits. Reset is synchronous;
// the label store needs no clearing.
// ----------------------------------------------------------------------------
module dns_query_encoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dqe_pkg::IN_DATA_W-1:0]  s_tdata,   // query_id[15:0], char_code[23:16]
  input  logic [1:0]                     s_tuser,   // opcode[1:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dqe_pkg::OUT_DATA_W-1:0] m_tdata,   // byte_first[7:0], byte_second[15:8],
                                                    // byte_count[17:16], item_done[18],
                                                    // status[21:19], zero[23:22]
  output logic                           m_tlast    // message_end
);

  import dqe_pkg::*;

  // Query state
  phase_t              phase;
  logic [LL_W-1:0]     ll;
  logic [NAME_W-1:0]   name_len;
  status_t             err;
  logic [7:0]          pending;
  logic [15:0]         qid;

  // Sequencer state
  logic                busy;
  pc_t                 pc;
  mode_t               mode;
  logic [IDX_W-1:0]    idx;
  logic [REM_W-1:0]    rem;
  status_t             run_status;

  // Byte pairing
  logic                have;
  logic [7:0]          first;

  // Output register
  logic [7:0]          out_first;
  logic [7:0]          out_second;
  logic [1:0]          out_count;
  logic                out_done;
  logic                out_end;
  status_t             out_status;

  // Control and datapath signals
  logic                in_go;
  opcode_t             op;
  logic [7:0]          in_char;
  ctrl_t               ctrl;
  logic                slot_free;
  logic                step_go;
  logic                at_last;
  logic                step_end;
  logic                cond_true;
  logic                emit_go;
  logic                stat_go;
  logic [7:0]          byte_val;
  logic [REM_W-1:0]    rem_dec;
  logic [IDX_W:0]      idx_inc;
  logic                budget_over;
  logic                open_q;
  logic                push;
  logic [7:0]          push_first;
  logic [7:0]          push_second;
  logic [1:0]          push_count;
  logic                push_done;
  logic                push_end;
  status_t             push_status;
  logic                lbl_wr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [7:0]          rd_data;

  assign s_tready = !busy;
  assign in_go    = s_tvalid && s_tready;
  assign op       = opcode_t'(s_tuser);
  assign in_char  = s_tdata[23:16];

  assign m_tdata = {2'b00, out_status, out_done, out_count, out_second, out_first};
  assign m_tlast = out_end;

  // Decode the current step
  assign ctrl      = ucode(pc);
  assign slot_free = !m_tvalid || m_tready;
  assign step_go   = busy && ((ctrl.src == SRC_NONE) || slot_free);
  assign idx_inc   = {1'b0, idx} + (IDX_W+1)'(1);
  assign rem_dec   = rem - REM_W'(1);
  assign open_q    = (phase == PH_OPEN) || (phase == PH_HELD);

  always_comb begin
    case (ctrl.src)
      SRC_HDR:  at_last = (idx == IDX_W'(HDR_BYTES - 1));
      SRC_LBL:  at_last = (idx_inc == (IDX_W+1)'(ll));
      SRC_TAIL: at_last = (idx == IDX_W'(TAIL_BYTES - 1));
      default:  at_last = 1'b1;
    endcase
  end

  assign step_end = step_go && (!ctrl.loop || at_last);

  always_comb begin
    case (ctrl.cond)
      COND_EMPTY: cond_true = (ll == '0);
      COND_DOT:   cond_true = (mode == MODE_DOT);
      default:    cond_true = 1'b0;
    endcase
  end

  // Select the byte of this step
  always_comb begin
    case (ctrl.src)
      SRC_HDR:  byte_val = hdr_byte(idx[3:0], qid);
      SRC_LEN:  byte_val = 8'(ll);
      SRC_LBL:  byte_val = rd_data;
      SRC_TAIL: byte_val = tail_byte(idx[3:0]);
      default:  byte_val = BYTE_ZERO;
    endcase
  end

  assign emit_go = step_go && ((ctrl.src == SRC_HDR) || (ctrl.src == SRC_LEN) ||
                               (ctrl.src == SRC_LBL) || (ctrl.src == SRC_TAIL));
  assign stat_go = step_go && (ctrl.src == SRC_STAT);

  // Pair bytes and form the result word
  always_comb begin
    push        = 1'b0;
    push_first  = BYTE_ZERO;
    push_second = BYTE_ZERO;
    push_count  = 2'd0;
    push_done   = 1'b0;
    push_end    = 1'b0;
    push_status = ST_OK;
    if (emit_go) begin
      if (have) begin
        push        = 1'b1;
        push_first  = first;
        push_second = byte_val;
        push_count  = 2'd2;
        push_done   = (rem_dec == '0) || ((mode == MODE_DOT) && (rem_dec == REM_W'(1)));
        push_end    = (rem_dec == '0) && (mode == MODE_END);
      end else if ((rem_dec == '0) && (mode == MODE_END)) begin
        push       = 1'b1;
        push_first = byte_val;
        push_count = 2'd1;
        push_done  = 1'b1;
        push_end   = 1'b1;
      end
    end else if (stat_go) begin
      push        = 1'b1;
      push_done   = 1'b1;
      push_end    = 1'b1;
      push_status = run_status;
    end
  end

  // Name budget check for the open label
  assign budget_over = (SUM_W'(name_len) + SUM_W'(ll) + SUM_W'(2)) > SUM_W'(QNAME_BUDGET);

  // Label store access
  assign lbl_wr = in_go && (op == OP_CHAR) && open_q && (in_char != CHAR_NUL) &&
                  (in_char != CHAR_DOT) && (ll < LL_W'(MAX_LABEL_BYTES));

  always_comb begin
    if (busy && (ctrl.src == SRC_LBL)) begin
      rd_addr = (step_go && !at_last) ? idx_inc[ADDR_W-1:0] : idx[ADDR_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  dqe_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LABEL_BYTES)
  ) u_label_ram (
    .clk     (clk),
    .wr_en   (lbl_wr),
    .wr_addr (ll[ADDR_W-1:0]),
    .wr_data (in_char),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_first  <= push_first;
      out_second <= push_second;
      out_count  <= push_count;
      out_done   <= push_done;
      out_end    <= push_end;
      out_status <= push_status;
    end
  end

  // Accept words and run the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      ll         <= '0;
      name_len   <= '0;
      err        <= ST_OK;
      pending    <= BYTE_ZERO;
      busy       <= 1'b0;
      pc         <= PC_HDR;
      mode       <= MODE_HDR;
      idx        <= '0;
      rem        <= '0;
      have       <= 1'b0;
      run_status <= ST_OK;
    end else begin
      if (in_go) begin
        unique case (op)
          OP_START: begin
            phase    <= PH_OPEN;
            ll       <= '0;
            name_len <= '0;
            err      <= ST_OK;
            pending  <= BYTE_ZERO;
            qid      <= s_tdata[15:0];
            busy     <= 1'b1;
            pc       <= PC_HDR;
            mode     <= MODE_HDR;
            idx      <= '0;
            rem      <= REM_W'(HDR_BYTES);
            have     <= 1'b0;
          end
          OP_CHAR: begin
            if (open_q && (in_char != CHAR_NUL)) begin
              if (in_char != CHAR_DOT) begin
                if (ll >= LL_W'(MAX_LABEL_BYTES)) begin
                  err   <= ST_LONG;
                  phase <= PH_FAIL;
                end else begin
                  ll <= ll + LL_W'(1);
                end
              end else if (ll == '0) begin
                err   <= ST_EMPTY;
                phase <= PH_FAIL;
              end else if (budget_over) begin
                err   <= ST_NAME;
                phase <= PH_FAIL;
              end else begin
                // Close the label: length byte, then its bytes
                name_len <= NAME_W'(SUM_W'(name_len) + SUM_W'(ll) + SUM_W'(1));
                phase    <= PH_OPEN;
                busy     <= 1'b1;
                pc       <= PC_NAME;
                mode     <= MODE_DOT;
                idx      <= '0;
                rem      <= REM_W'(ll) + REM_W'(1);
                have     <= (phase == PH_HELD);
                first    <= pending;
              end
            end
          end
          OP_END: begin
            busy <= 1'b1;
            idx  <= '0;
            if (phase == PH_IDLE) begin
              pc         <= PC_STAT;
              run_status <= ST_NOQ;
            end else if (phase == PH_FAIL) begin
              pc         <= PC_STAT;
              run_status <= err;
              phase      <= PH_IDLE;
            end else if ((ll != '0) && budget_over) begin
              pc         <= PC_STAT;
              run_status <= ST_NAME;
              phase      <= PH_IDLE;
            end else begin
              // Flush the last label, then root, QTYPE and QCLASS
              pc      <= PC_NAME;
              mode    <= MODE_END;
              rem     <= (ll != '0) ? (REM_W'(ll) + REM_W'(1 + TAIL_BYTES))
                                    : REM_W'(TAIL_BYTES);
              have    <= (phase == PH_HELD);
              first   <= pending;
              phase   <= PH_IDLE;
              pending <= BYTE_ZERO;
            end
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end

      // Pair the emitted byte or hold an odd one
      if (emit_go) begin
        rem <= rem_dec;
        if (have) begin
          have <= 1'b0;
        end else if (rem_dec == '0) begin
          if (mode == MODE_DOT) begin
            pending <= byte_val;
            phase   <= PH_HELD;
          end
        end else begin
          first <= byte_val;
          have  <= 1'b1;
        end
      end

      // Advance the step counter
      if (step_go) begin
        if (step_end) begin
          idx <= '0;
          if (ctrl.fin) begin
            busy <= 1'b0;
            ll   <= '0;
          end else if (cond_true) begin
            pc <= ctrl.target;
          end else begin
            pc <= pc + pc_t'(1);
          end
        end else begin
          idx <= idx_inc[IDX_W-1:0];
        end
      end
    end
  end

  // Never emit more bytes than the program counted
  a_rem_left: assert property (@(posedge clk) disable iff (rst)
    emit_go |-> (rem != '0))
    else $error("byte emitted with no bytes left");

  // Label reads stay inside the open label
  a_lbl_range: assert property (@(posedge clk) disable iff (rst)
    (busy && (ctrl.src == SRC_LBL)) |-> (idx_inc <= (IDX_W+1)'(ll)))
    else $error("label read beyond label length");

  // A finished program leaves no half pair behind
  a_pair_empty: assert property (@(posedge clk) disable iff (rst)
    (step_end && ctrl.fin) |=> !have)
    else $error("byte left in pair register at program end");

  // The message end word also closes its item
  a_end_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> out_done)
    else $error("message end without item done");

endmodule
